@@ design/rmb_pkg.sv @@
// ----------------------------------------------------------------------------
// rmb_pkg: shared types and constants for the rotation matrix builder
// Axis modes, the queued word format, fixed-point constants and stage counts.
// ----------------------------------------------------------------------------
`default_nettype none

package rmb_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int ATAN_LEN      = 24;

  // square root of a 60-bit radicand: one result bit per stage
  localparam int SQRT_STEPS = 31;
  // 31 quotient bits cover unit components up to and just past one
  localparam int DIV_STEPS  = 31;

  localparam logic signed [33:0] Q30_HALF_PI = 34'sh06487ED51;
  localparam logic signed [33:0] Q30_PI      = 34'sh0C90FDAA2;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;
  localparam logic signed [32:0] Q30_ONE     = 33'sh040000000;

  localparam int OUT_HI = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam int OUT_LO = (-(1 << OUT_FRAC_BITS) < -32768) ? -32768 : -(1 << OUT_FRAC_BITS);
  localparam logic signed [15:0] OUT_ONE_W = 16'(OUT_HI);
  localparam logic signed [15:0] OUT_MIN_W = 16'(OUT_LO);

  typedef enum logic [1:0] {
    FUNC_X,
    FUNC_Y,
    FUNC_Z,
    FUNC_AXIS
  } rmb_func_t;

  typedef struct packed {
    rmb_func_t          func;
    logic               zero;
    logic [2:0]         sgn;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;
    logic [15:0]        mag_z;
    logic [31:0]        len2;
    logic signed [32:0] ang;
    logic               neg;
  } rmb_item_t;

endpackage

`default_nettype wire

@@ design/rmb_front.sv @@
// ----------------------------------------------------------------------------
// rmb_front: input stage
// Accept words, classify the axis mode, fold the angle, form squared axis length.
// ----------------------------------------------------------------------------
`default_nettype none

module rmb_front import rmb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // axis_x, axis_y, axis_z, angle
  input  wire logic [1:0]  s_tuser,  // func
  input  wire logic        q_full,
  output logic             push,
  output rmb_item_t        push_item
);

  logic                fv;
  rmb_item_t           item_next;
  logic signed [15:0]  ax, ay, az, ang16;
  logic signed [31:0]  sqx, sqy, sqz;
  logic signed [33:0]  a34, af;
  logic                neg;

  assign ax    = $signed(s_tdata[15:0]);
  assign ay    = $signed(s_tdata[31:16]);
  assign az    = $signed(s_tdata[47:32]);
  assign ang16 = $signed(s_tdata[63:48]);
  assign sqx   = 32'(ax) * 32'(ax);
  assign sqy   = 32'(ay) * 32'(ay);
  assign sqz   = 32'(az) * 32'(az);
  assign a34   = 34'($signed({ang16, 17'd0}));

  always_comb begin
    af  = a34;
    neg = 1'b0;
    if (a34 > Q30_HALF_PI) begin
      af  = a34 - Q30_PI;
      neg = 1'b1;
    end else if (a34 < -Q30_HALF_PI) begin
      af  = a34 + Q30_PI;
      neg = 1'b1;
    end
  end

  always_comb begin
    item_next.func  = rmb_func_t'(s_tuser);
    item_next.len2  = 32'(sqx) + 32'(sqy) + 32'(sqz);
    item_next.zero  = (item_next.func == FUNC_AXIS) && (item_next.len2 == 32'd0);
    item_next.sgn   = {az[15], ay[15], ax[15]};
    item_next.mag_x = ax[15] ? 16'(-ax) : 16'(ax);
    item_next.mag_y = ay[15] ? 16'(-ay) : 16'(ay);
    item_next.mag_z = az[15] ? 16'(-az) : 16'(az);
    item_next.ang   = af[32:0];
    item_next.neg   = neg;
  end

  assign s_tready = !fv || !q_full;
  assign push     = fv && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      push_item <= item_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rmb_queue.sv @@
// ----------------------------------------------------------------------------
// rmb_queue: two-entry queue between front and back
// Hold classified words so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rmb_queue import rmb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire rmb_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output rmb_item_t      head_item
);

  rmb_item_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push_ok, pop_ok;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = mem[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ design/rmb_back.sv @@
// ----------------------------------------------------------------------------
// rmb_back: compute pipeline
// CORDIC sine and cosine, axis square root and divide, Rodrigues products.
// ----------------------------------------------------------------------------
`default_nettype none

module rmb_back import rmb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire rmb_item_t    q_item,
  output logic              q_pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,
  output logic [0:0]        m_tuser
);

  localparam int SQ   = SQRT_STEPS;
  localparam int DV   = DIV_STEPS;
  localparam int M    = SQ + DV;
  localparam int LAST = M + 4;
  localparam int SH   = 30 - OUT_FRAC_BITS;
  localparam logic signed [34:0] RND = 35'((64'sd1 <<< SH) >>> 1);

  typedef struct packed {
    rmb_func_t   func;
    logic        zero;
    logic [2:0]  sgn;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [15:0] mag_z;
  } rmb_meta_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] a;
    logic               neg;
  } rmb_rot_t;

  function automatic logic signed [32:0] atan_q30(input int i);
    logic signed [32:0] r;
    case (i)
      0:  r = 33'sh03243F6A8;  1:  r = 33'sh01DAC6705;
      2:  r = 33'sh00FADBAFC;  3:  r = 33'sh007F56EA6;
      4:  r = 33'sh003FEAB76;  5:  r = 33'sh001FFD55B;
      6:  r = 33'sh000FFFAAA;  7:  r = 33'sh0007FFF55;
      8:  r = 33'sh0003FFFEA;  9:  r = 33'sh0001FFFFD;
      10: r = 33'sh0000FFFFF;  11: r = 33'sh00007FFFF;
      12: r = 33'sh00003FFFF;  13: r = 33'sh00001FFFF;
      14: r = 33'sh00000FFFF;  15: r = 33'sh000007FFF;
      16: r = 33'sh000003FFF;  17: r = 33'sh000001FFF;
      18: r = 33'sh000000FFF;  19: r = 33'sh0000007FF;
      20: r = 33'sh0000003FF;  21: r = 33'sh0000001FF;
      22: r = 33'sh0000000FF;  23: r = 33'sh00000007F;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    return 33'(p >>> 30);
  endfunction

  function automatic logic signed [32:0] cap_sign(input logic [30:0] q, input logic sg);
    logic [30:0] m;
    m = (q > 31'(Q30_ONE)) ? 31'(Q30_ONE) : q;
    return sg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  function automatic logic [15:0] to_out(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = (35'(v) + RND) >>> SH;
    if (r > 35'(OUT_HI)) r = 35'(OUT_HI);
    if (r < 35'(OUT_LO)) r = 35'(OUT_LO);
    return r[15:0];
  endfunction

  logic [LAST:1] v;
  logic          en;

  assign en       = !v[LAST] || m_tready;
  assign q_pop    = en && q_valid;
  assign m_tvalid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAST-1:1], q_valid};
    end
  end

  // item fields that ride along with the square root and divide
  rmb_meta_t meta [1:M];

  always_ff @(posedge clk) begin
    if (en) begin
      meta[1] <= '{func: q_item.func, zero: q_item.zero, sgn: q_item.sgn,
                   mag_x: q_item.mag_x, mag_y: q_item.mag_y, mag_z: q_item.mag_z};
      for (int k = 2; k <= M; k++) meta[k] <= meta[k-1];
    end
  end

  // CORDIC, then delay up to the divide output
  rmb_rot_t rot [1:M];
  rmb_rot_t rot0;

  assign rot0 = '{x: CORDIC_GAIN, y: 33'sd0, a: q_item.ang, neg: q_item.neg};

  for (genvar k = 1; k <= M; k++) begin : g_rot
    rmb_rot_t src, nxt;
    if (k == 1) begin : g_first
      assign src = rot0;
    end else begin : g_next
      assign src = rot[k-1];
    end
    if (k <= CORDIC_STEPS) begin : g_step
      always_comb begin
        nxt = src;
        if (!src.a[32]) begin
          nxt.x = src.x - ($signed(src.y) >>> (k-1));
          nxt.y = src.y + ($signed(src.x) >>> (k-1));
          nxt.a = src.a - atan_q30(k-1);
        end else begin
          nxt.x = src.x + ($signed(src.y) >>> (k-1));
          nxt.y = src.y - ($signed(src.x) >>> (k-1));
          nxt.a = src.a + atan_q30(k-1);
        end
      end
    end else begin : g_pass
      assign nxt = src;
    end
    always_ff @(posedge clk) begin
      if (en) rot[k] <= nxt;
    end
  end

  // square root of len2 * 2^28, one root bit per stage
  logic [60:0] sq_n [1:SQ];
  logic [60:0] sq_r [1:SQ];

  for (genvar k = 1; k <= SQ; k++) begin : g_sq
    localparam logic [60:0] B = 61'(1) << (2 * (SQ - k));
    logic [60:0] n_in, r_in, n_nxt, r_nxt, sum;
    if (k == 1) begin : g_first
      assign n_in = 61'({q_item.len2, 28'd0});
      assign r_in = '0;
    end else begin : g_next
      assign n_in = sq_n[k-1];
      assign r_in = sq_r[k-1];
    end
    always_comb begin
      sum = r_in + B;
      if (n_in >= sum) begin
        n_nxt = n_in - sum;
        r_nxt = (r_in >> 1) + B;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[k] <= n_nxt;
        sq_r[k] <= r_nxt;
      end
    end
  end

  // restoring divide, three lanes, one quotient bit per stage
  logic [29:0] dv_s   [1:DV];
  logic [29:0] dv_rem [1:DV][3];
  logic [30:0] dv_low [1:DV][3];
  logic [30:0] dv_q   [1:DV][3];

  for (genvar j = 1; j <= DV; j++) begin : g_dv
    logic [29:0] s_in;
    logic [29:0] rem_in [3];
    logic [30:0] low_in [3];
    logic [30:0] q_in   [3];
    logic [29:0] rem_nxt [3];
    logic [30:0] q_nxt  [3];
    if (j == 1) begin : g_first
      logic [59:0] num [3];
      logic [15:0] mag [3];
      assign s_in   = sq_r[SQ][29:0];
      assign mag[0] = meta[SQ].mag_x;
      assign mag[1] = meta[SQ].mag_y;
      assign mag[2] = meta[SQ].mag_z;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign num[l]    = {mag[l], 44'd0} + 60'(s_in >> 1);
        assign rem_in[l] = 30'(num[l][59:31]);
        assign low_in[l] = num[l][30:0];
        assign q_in[l]   = '0;
      end
    end else begin : g_next
      assign s_in = dv_s[j-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = dv_rem[j-1][l];
        assign low_in[l] = dv_low[j-1][l];
        assign q_in[l]   = dv_q[j-1][l];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_step
      logic [30:0] t;
      assign t = {rem_in[l], low_in[l][30]};
      always_comb begin
        if (t >= {1'b0, s_in}) begin
          rem_nxt[l] = 30'(t - {1'b0, s_in});
          q_nxt[l]   = {q_in[l][29:0], 1'b1};
        end else begin
          rem_nxt[l] = t[29:0];
          q_nxt[l]   = {q_in[l][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[j] <= s_in;
        for (int l = 0; l < 3; l++) begin
          dv_rem[j][l] <= rem_nxt[l];
          dv_low[j][l] <= {low_in[l][29:0], 1'b0};
          dv_q[j][l]   <= q_nxt[l];
        end
      end
    end
  end

  // unit axis, signed sine and cosine
  logic signed [32:0] ux, uy, uz, cc, ss;
  logic               zf;

  always_ff @(posedge clk) begin
    if (en) begin
      cc <= rot[M].neg ? -rot[M].x : rot[M].x;
      ss <= rot[M].neg ? -rot[M].y : rot[M].y;
      zf <= meta[M].zero;
      unique case (meta[M].func)
        FUNC_X: begin
          ux <= Q30_ONE; uy <= '0; uz <= '0;
        end
        FUNC_Y: begin
          ux <= '0; uy <= Q30_ONE; uz <= '0;
        end
        FUNC_Z: begin
          ux <= '0; uy <= '0; uz <= Q30_ONE;
        end
        FUNC_AXIS: begin
          ux <= cap_sign(dv_q[DV][0], meta[M].sgn[0]);
          uy <= cap_sign(dv_q[DV][1], meta[M].sgn[1]);
          uz <= cap_sign(dv_q[DV][2], meta[M].sgn[2]);
        end
      endcase
    end
  end

  // axis products and axis-sine terms
  logic signed [32:0] pxx, pxy, pxz, pyy, pyz, pzz, pxs, pys, pzs, tt, c1;
  logic               z1;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= mulq(ux, ux);
      pxy <= mulq(ux, uy);
      pxz <= mulq(ux, uz);
      pyy <= mulq(uy, uy);
      pyz <= mulq(uy, uz);
      pzz <= mulq(uz, uz);
      pxs <= mulq(ux, ss);
      pys <= mulq(uy, ss);
      pzs <= mulq(uz, ss);
      tt  <= Q30_ONE - cc;
      c1  <= cc;
      z1  <= zf;
    end
  end

  // scale by one minus cosine
  logic signed [32:0] qxx, qxy, qxz, qyy, qyz, qzz, xs2, ys2, zs2, c2;
  logic               z2;

  always_ff @(posedge clk) begin
    if (en) begin
      qxx <= mulq(pxx, tt);
      qxy <= mulq(pxy, tt);
      qxz <= mulq(pxz, tt);
      qyy <= mulq(pyy, tt);
      qyz <= mulq(pyz, tt);
      qzz <= mulq(pzz, tt);
      xs2 <= pxs;
      ys2 <= pys;
      zs2 <= pzs;
      c2  <= c1;
      z2  <= z1;
    end
  end

  // sum, round and clamp
  logic signed [33:0] m [9];

  always_comb begin
    m[0] = 34'(qxx) + 34'(c2);
    m[1] = 34'(qxy) + 34'(zs2);
    m[2] = 34'(qxz) - 34'(ys2);
    m[3] = 34'(qxy) - 34'(zs2);
    m[4] = 34'(qyy) + 34'(c2);
    m[5] = 34'(qyz) + 34'(xs2);
    m[6] = 34'(qxz) + 34'(ys2);
    m[7] = 34'(qyz) - 34'(xs2);
    m[8] = 34'(qzz) + 34'(c2);
    if (z2) begin
      for (int i = 0; i < 9; i++) begin
        m[i] = (i % 4 == 0) ? 34'(Q30_ONE) : 34'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) m_tdata[16*i +: 16] <= to_out(m[i]);
      m_tuser[0] <= z2;
    end
  end

endmodule

`default_nettype wire

@@ design/rotation_matrix_builder.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_builder: axis-angle to 3x3 rotation matrix
// Takes one word per cycle unless output back-pressure fills the queue, and
// returns the rotation part of a row-major rotation matrix in Q1.14, one
// result word per input word, in order. One front register and one queue
// slot lead into 66 back stages set by the 31-stage axis square root and
// 31-stage divide, followed by unit-axis, two multiply and one output stage.
// The CORDIC runs alongside the square root. A stalled output holds the whole
// back pipeline; the two-entry queue and front register absorb the stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_builder import rmb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,  // axis_x, axis_y, axis_z, angle
  input  wire logic [1:0]   s_tuser,  // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2
  output logic [0:0]        m_tuser   // axis_zero
);

  logic      push, q_full, q_valid, q_pop;
  rmb_item_t push_item, q_item;

  rmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  rmb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ design/rmb_checker.sv @@
// ----------------------------------------------------------------------------
// rmb_checker: port-level checks for the rotation matrix builder
// Output handshake, reset, identity on zero axis, range of the first and last diagonal elements.
// ----------------------------------------------------------------------------
`default_nettype none

module rmb_checker import rmb_pkg::*; (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [143:0] m_tdata,
  input wire logic [0:0]   m_tuser
);

  localparam logic [143:0] IDENT = {OUT_ONE_W, 16'd0, 16'd0, 16'd0, OUT_ONE_W,
                                    16'd0, 16'd0, 16'd0, OUT_ONE_W};

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == IDENT)
    else $error("zero axis without identity matrix");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= OUT_ONE_W &&
                 $signed(m_tdata[15:0]) >= OUT_MIN_W &&
                 $signed(m_tdata[143:128]) <= OUT_ONE_W &&
                 $signed(m_tdata[143:128]) >= OUT_MIN_W)
    else $error("diagonal element out of range");

endmodule

bind rotation_matrix_builder rmb_checker u_rmb_checker (.*);

`default_nettype wire

@@ bench/rotation_matrix_builder_tb.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_builder_tb: self-checking bench for the rotation builder
// Feeds axis-angle words through the input stream, computes the expected
// fixed-point rotation matrix per word and compares every output word in
// order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_builder_tb import rmb_pkg::*;;

  typedef struct packed {
    rmb_func_t          func;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic [143:0] elems;
    logic         zero;
  } rot_mat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [0:0]   m_tuser;

  rot_req_t req_q[$];
  rot_mat_t mat_q[$];
  int       errors = 0;
  bit       hold_send = 1'b0;
  bit       calm = 1'b0;

  longint atan_rom[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  rotation_matrix_builder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),    // axis_x, axis_y, axis_z, angle
    .s_tuser(s_tuser),    // func
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata),    // r0c0 .. r2c2
    .m_tuser(m_tuser)     // axis_zero
  );

  always #5 clk = ~clk;

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_axis(longint a, longint unsigned s);
    longint unsigned mag, q;
    mag = a < 0 ? -a : a;
    q = ((mag << 44) + (s >> 1)) / s;
    if (q > 64'd1 << 30) q = 64'd1 << 30;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint one;
    int sh;
    sh = 30 - OUT_FRAC_BITS;
    one = 64'sd1 <<< OUT_FRAC_BITS;
    if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic rot_mat_t build_rotation(rot_req_t r);
    rot_mat_t res;
    longint a, cx, cy, dx, dy, ux, uy, uz, c, s, t, ax, ay, az;
    longint m[9];
    longint unsigned len2, sq;
    bit neg, zero;
    a = longint'(r.angle) <<< 17;
    cx = 64'sh26DD3B6A;
    cy = 0;
    ux = 0; uy = 0; uz = 0;
    neg = 0; zero = 0;
    if (a > 64'sh6487ED51) begin
      a -= 2 * 64'sh6487ED51; neg = 1;
    end else if (a < -64'sh6487ED51) begin
      a += 2 * 64'sh6487ED51; neg = 1;
    end
    for (int i = 0; i < (CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS); i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (a >= 0) begin
        cx -= dx; cy += dy; a -= atan_rom[i];
      end else begin
        cx += dx; cy -= dy; a += atan_rom[i];
      end
    end
    c = neg ? -cx : cx;
    s = neg ? -cy : cy;
    case (r.func)
      FUNC_X: ux = 64'sd1 <<< 30;
      FUNC_Y: uy = 64'sd1 <<< 30;
      FUNC_Z: uz = 64'sd1 <<< 30;
      default: begin
        ax = r.ax; ay = r.ay; az = r.az;
        len2 = ax * ax + ay * ay + az * az;
        if (len2 == 0) begin
          zero = 1;
        end else begin
          sq = root64(len2 << 28);
          ux = unit_axis(ax, sq);
          uy = unit_axis(ay, sq);
          uz = unit_axis(az, sq);
        end
      end
    endcase
    if (zero) begin
      for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
    end else begin
      t = (64'sd1 <<< 30) - c;
      m[0] = qmul(qmul(ux, ux), t) + c;
      m[1] = qmul(qmul(ux, uy), t) + qmul(uz, s);
      m[2] = qmul(qmul(ux, uz), t) - qmul(uy, s);
      m[3] = qmul(qmul(ux, uy), t) - qmul(uz, s);
      m[4] = qmul(qmul(uy, uy), t) + c;
      m[5] = qmul(qmul(uy, uz), t) + qmul(ux, s);
      m[6] = qmul(qmul(ux, uz), t) + qmul(uy, s);
      m[7] = qmul(qmul(uy, uz), t) - qmul(ux, s);
      m[8] = qmul(qmul(uz, uz), t) + c;
    end
    for (int i = 0; i < 9; i++) res.elems[16*i +: 16] = to_q14(m[i]);
    res.zero = zero;
    return res;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) void'(req_q.pop_front());
      if (s_tvalid && !s_tready) begin
        // hold the word until accepted
      end else if (req_q.size() > 0 && !hold_send &&
                   (calm || $urandom_range(0, 99) >= 10)) begin
        rot_req_t nx;
        nx = req_q[0];
        s_tvalid <= 1'b1;
        s_tuser  <= nx.func;
        s_tdata  <= {nx.angle, nx.az, nx.ay, nx.ax};
        mat_q.push_back(build_rotation(nx));
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= calm || $urandom_range(0, 99) >= 10;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (mat_q.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        rot_mat_t e;
        e = mat_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (m_tdata[16*i +: 16] !== e.elems[16*i +: 16]) begin
            $error("r%0dc%0d expected %0d got %0d", i / 3, i % 3,
                   $signed(e.elems[16*i +: 16]), $signed(m_tdata[16*i +: 16]));
            errors++;
          end
        if (m_tuser[0] !== e.zero) begin
          $error("axis_zero expected %0d got %0d", e.zero, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic add_req(rmb_func_t f, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z, logic [15:0] ang);
    rot_req_t r;
    r.func = f; r.ax = x; r.ay = y; r.az = z; r.angle = ang;
    req_q.push_back(r);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    add_req(FUNC_X, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_req(FUNC_Y, 16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF);
    add_req(FUNC_Z, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    add_req(FUNC_AXIS, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
    add_req(FUNC_AXIS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h3244);
    add_req(FUNC_AXIS, 16'h8000, 16'h8000, 16'h8000, 16'hCDBC);
    add_req(FUNC_AXIS, 16'h8000, 16'h0000, 16'h0000, 16'h6488);
    add_req(FUNC_AXIS, 16'h0001, 16'h0000, 16'h0000, 16'h9B78);
    add_req(FUNC_AXIS, 16'h0000, 16'hFFFF, 16'h0000, 16'h3243);
    add_req(FUNC_AXIS, 16'h0000, 16'h0000, 16'h7FFF, 16'hCDBD);
    add_req(FUNC_AXIS, 16'h0003, 16'h0004, 16'h0000, 16'h6487);
    add_req(FUNC_X, 16'h0000, 16'h0000, 16'h0000, 16'h6488);
    add_req(FUNC_Y, 16'h0000, 16'h0000, 16'h0000, 16'h9B78);
    add_req(FUNC_Z, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    add_req(FUNC_AXIS, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001);
    while (req_q.size() > 0) @(posedge clk);
    hold_send = 1'b1;
    while (mat_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    for (int n = 0; n < 1650; n++) begin
      if (n == 600) calm = 1'b1;
      if (n == 900) calm = 1'b0;
      add_req(rmb_func_t'($urandom_range(0, 3)), pick16(), pick16(), pick16(),
              pick16());
      if (req_q.size() > 20) @(posedge clk);
    end
    while (req_q.size() > 0 || s_tvalid) @(posedge clk);
    while (mat_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("rotation_matrix_builder_tb: done, clean");
    else
      $display("rotation_matrix_builder_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_builder_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/rmb_pkg.sv
design/rmb_front.sv
design/rmb_queue.sv
design/rmb_back.sv
design/rotation_matrix_builder.sv
design/rmb_checker.sv
bench/rotation_matrix_builder_tb.sv
